>>> hw/rtl/rwrms_pkg.sv
// Shared types and constants for the rectified windowed RMS level meter.
// Depends on nothing; used by rectified_windowed_rms_level (rwrms_ram does not use it).
`timescale 1ns / 1ps

package rwrms_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int REG_W       = 10;
  localparam int CFG_IDX_W   = 8;
  localparam int WINDOW_DEF  = 10;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
  localparam logic [REG_W-1:0]       MID_RESET  = REG_W'(458);
  localparam logic [REG_W-1:0]       PEAK_RESET = REG_W'(650);

  localparam logic [CFG_IDX_W-1:0] CFG_MID_LEVEL  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_LEVEL = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPD,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } rwrms_state_t;

endpackage

>>> hw/rtl/rectified_windowed_rms_level.sv
// From input beat to result beat: window read, sum update, one reciprocal
// multiply for the divide by WINDOW, SAMPLE_BITS root steps on one shared
// subtractor, then the result is registered together with the beat in ST_DONE.
// Samples are taken one at a time: in_stall holds while one is in flight; the next beat
// is taken once the result sits in the output register.
// Reset: window reads as zero, mid_level 458, peak_level 650.
`timescale 1ns / 1ps

module rectified_windowed_rms_level #(
  parameter int WINDOW = rwrms_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rwrms_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rwrms_pkg::SAMPLE_BITS-1:0] out_rms_level,
  output logic [rwrms_pkg::SAMPLE_BITS-1:0] out_folded_sample,
  output logic                            out_peak_flag,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rwrms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rwrms_pkg::REG_W-1:0]       cfg_data
);

  localparam int SB        = rwrms_pkg::SAMPLE_BITS;
  localparam int AW        = $clog2(WINDOW);
  localparam int SQ_W      = 2 * SB;
  localparam int MEAN_W    = 2 * SB;
  localparam int SUM_W     = SQ_W + AW;
  localparam int ROOT_W    = SB;
  localparam int ALU_W     = ROOT_W + 3;
  localparam int STEP_W    = $clog2(ROOT_W);
  localparam int PROD_W    = 2 * SUM_W + 1;
  localparam int DIV_SHIFT = SUM_W + AW;
  localparam logic [SUM_W:0] DIV_RECIP =
    (SUM_W+1)'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  rwrms_pkg::rwrms_state_t state_r, state_nxt;

  logic [rwrms_pkg::REG_W-1:0] mid_r, mid_nxt;
  logic [rwrms_pkg::REG_W-1:0] peak_r, peak_nxt;
  logic [WINDOW-1:0]           valid_r, valid_nxt;
  logic [AW-1:0]               slot_r, slot_nxt;
  logic [SUM_W-1:0]            sum_r, sum_nxt;
  logic [SB-1:0]               folded_r, folded_nxt;
  logic [SQ_W-1:0]             sq_old_r, sq_old_nxt;
  logic [ALU_W-1:0]            rem_r, rem_nxt;
  logic [MEAN_W-1:0]           dq_r, dq_nxt;
  logic [ROOT_W-1:0]           root_r, root_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [SB-1:0]               rms_out_r, rms_out_nxt;
  logic [SB-1:0]               fold_out_r, fold_out_nxt;
  logic                        peak_out_r, peak_out_nxt;

  logic              in_take;
  logic [SB+1:0]     fold_calc;
  logic [SB-1:0]     fold_val;
  logic [SB-1:0]     ram_rd_data;
  logic [SB-1:0]     old_val;
  logic [SUM_W-1:0]  sum_calc;
  logic [PROD_W-1:0] div_prod;
  logic [ALU_W-1:0]  alu_a, alu_b;
  logic [ALU_W:0]    alu_diff;
  logic              alu_ge;

  rwrms_ram #(
    .WIDTH (SB),
    .DEPTH (WINDOW)
  ) u_window (
    .clk     (clk),
    .wr_en   (state_r == rwrms_pkg::ST_READ),
    .wr_addr (slot_r),
    .wr_data (folded_r),
    .rd_en   (in_take),
    .rd_addr (slot_r),
    .rd_data (ram_rd_data)
  );

  assign in_stall  = (state_r != rwrms_pkg::ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign fold_calc = {1'b0, mid_r, 1'b0} - (SB+2)'(in_sample);
  assign fold_val  = (in_sample > mid_r) ? in_sample :
                     (fold_calc > (SB+2)'(rwrms_pkg::SAMPLE_MAX)) ? rwrms_pkg::SAMPLE_MAX :
                     fold_calc[SB-1:0];

  assign old_val  = valid_r[slot_r] ? ram_rd_data : '0;
  assign sum_calc = sum_r - SUM_W'(sq_old_r) + SUM_W'(SQ_W'(folded_r) * SQ_W'(folded_r));
  assign div_prod = PROD_W'(sum_r) * PROD_W'(DIV_RECIP);

  // shared compare/subtract for the root steps
  always_comb begin
    alu_a    = {rem_r[ALU_W-3:0], dq_r[MEAN_W-1 -: 2]};
    alu_b    = ALU_W'({root_r, 2'b01});
    alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    alu_ge   = !alu_diff[ALU_W];
  end

  always_comb begin
    state_nxt     = state_r;
    mid_nxt       = mid_r;
    peak_nxt      = peak_r;
    valid_nxt     = valid_r;
    slot_nxt      = slot_r;
    sum_nxt       = sum_r;
    folded_nxt    = folded_r;
    sq_old_nxt    = sq_old_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    root_nxt      = root_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    rms_out_nxt   = rms_out_r;
    fold_out_nxt  = fold_out_r;
    peak_out_nxt  = peak_out_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == rwrms_pkg::CFG_MID_LEVEL) begin
        mid_nxt = cfg_data;
      end else if (cfg_index == rwrms_pkg::CFG_PEAK_LEVEL) begin
        peak_nxt = cfg_data;
      end
    end

    case (state_r)
      rwrms_pkg::ST_IDLE: begin
        if (in_take) begin
          folded_nxt = fold_val;
          state_nxt  = rwrms_pkg::ST_READ;
        end
      end
      rwrms_pkg::ST_READ: begin
        sq_old_nxt       = SQ_W'(old_val) * SQ_W'(old_val);
        valid_nxt[slot_r] = 1'b1;
        state_nxt        = rwrms_pkg::ST_UPD;
      end
      rwrms_pkg::ST_UPD: begin
        sum_nxt   = sum_calc;
        slot_nxt  = (32'(slot_r) == WINDOW - 1) ? '0 : slot_r + AW'(1);
        state_nxt = rwrms_pkg::ST_DIV;
      end
      rwrms_pkg::ST_DIV: begin
        dq_nxt    = div_prod[DIV_SHIFT +: MEAN_W];
        rem_nxt   = '0;
        root_nxt  = '0;
        step_nxt  = '0;
        state_nxt = rwrms_pkg::ST_SQRT;
      end
      rwrms_pkg::ST_SQRT: begin
        dq_nxt   = {dq_r[MEAN_W-3:0], 2'b00};
        root_nxt = {root_r[ROOT_W-2:0], alu_ge};
        if (alu_ge) begin
          rem_nxt = alu_diff[ALU_W-1:0];
        end else begin
          rem_nxt = alu_a;
        end
        step_nxt = step_r + STEP_W'(1);
        if (32'(step_r) == ROOT_W - 1) begin
          state_nxt = rwrms_pkg::ST_DONE;
        end
      end
      rwrms_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          rms_out_nxt   = root_r;
          fold_out_nxt  = folded_r;
          peak_out_nxt  = (folded_r > peak_r);
          state_nxt     = rwrms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rwrms_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rwrms_pkg::ST_IDLE;
      mid_r       <= rwrms_pkg::MID_RESET;
      peak_r      <= rwrms_pkg::PEAK_RESET;
      valid_r     <= '0;
      slot_r      <= '0;
      sum_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mid_r       <= mid_nxt;
      peak_r      <= peak_nxt;
      valid_r     <= valid_nxt;
      slot_r      <= slot_nxt;
      sum_r       <= sum_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    folded_r   <= folded_nxt;
    sq_old_r   <= sq_old_nxt;
    rem_r      <= rem_nxt;
    dq_r       <= dq_nxt;
    root_r     <= root_nxt;
    rms_out_r  <= rms_out_nxt;
    fold_out_r <= fold_out_nxt;
    peak_out_r <= peak_out_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_rms_level     = rms_out_r;
  assign out_folded_sample = fold_out_r;
  assign out_peak_flag     = peak_out_r;

endmodule

>>> hw/rtl/rwrms_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rwrms_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
